@@ hdl/tss_pkg.sv @@
// Shared types and constants for the traffic signal sequencer.
// Used by the lamp decoder, the top level and the port checker; no dependencies.
package tss_pkg;

  localparam int unsigned SecsW   = 5;
  localparam int unsigned LightW  = 10;
  localparam int unsigned ThreshW = 11;
  localparam int unsigned CfgAW   = 3;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [CfgAW-1:0] {
    REG_NS_GREEN   = 3'd0,
    REG_EW_GREEN   = 3'd1,
    REG_TURN_GREEN = 3'd2,
    REG_YELLOW     = 3'd3,
    REG_NS_WALK    = 3'd4,
    REG_EW_WALK    = 3'd5,
    REG_DARK_THR   = 3'd6
  } tss_reg_t;

  typedef enum logic [3:0] {
    PH_START      = 4'd0,
    PH_NS_WALK    = 4'd1,
    PH_NS_GREEN   = 4'd2,
    PH_NS_YELLOW  = 4'd3,
    PH_EWT_GREEN  = 4'd4,
    PH_EWT_YELLOW = 4'd5,
    PH_EW_WALK    = 4'd6,
    PH_EW_GREEN   = 4'd7,
    PH_EW_YELLOW  = 4'd8,
    PH_NST_GREEN  = 4'd9,
    PH_NST_YELLOW = 4'd10
  } tss_phase_t;

  typedef enum logic [1:0] {
    COL_OFF    = 2'd0,
    COL_RED    = 2'd1,
    COL_GREEN  = 2'd2,
    COL_YELLOW = 2'd3
  } tss_color_t;

  typedef enum logic [1:0] {
    APPR_NS  = 2'd0,
    APPR_NST = 2'd1,
    APPR_EW  = 2'd2,
    APPR_EWT = 2'd3
  } tss_appr_t;

  // Lamp and walk indications for one phase.
  typedef struct packed {
    tss_color_t ns;
    tss_color_t nst;
    tss_color_t ew;
    tss_color_t ewt;
    tss_appr_t  appr;
    logic       walk;
    logic       walk_ew;
  } tss_lamp_t;

endpackage

@@ hdl/tss_lamp_decode.sv @@
// Lamp decoder: maps the current phase to the four lamp colors and walk flags.
// Depends on tss_pkg.
module tss_lamp_decode (
  input  tss_pkg::tss_phase_t phase,
  output tss_pkg::tss_lamp_t  lamp
);
  import tss_pkg::*;

  always_comb begin
    lamp = '{ns: COL_RED, nst: COL_RED, ew: COL_RED, ewt: COL_RED,
             appr: APPR_NS, walk: 1'b0, walk_ew: 1'b0};
    case (phase)
      PH_NS_WALK: begin
        lamp.ns   = COL_GREEN;
        lamp.walk = 1'b1;
      end
      PH_NS_GREEN:   lamp.ns = COL_GREEN;
      PH_NS_YELLOW:  lamp.ns = COL_YELLOW;
      PH_EWT_GREEN: begin
        lamp.ewt  = COL_GREEN;
        lamp.appr = APPR_EWT;
      end
      PH_EWT_YELLOW: begin
        lamp.ewt  = COL_YELLOW;
        lamp.appr = APPR_EWT;
      end
      PH_EW_WALK: begin
        lamp.ew      = COL_GREEN;
        lamp.appr    = APPR_EW;
        lamp.walk    = 1'b1;
        lamp.walk_ew = 1'b1;
      end
      PH_EW_GREEN: begin
        lamp.ew   = COL_GREEN;
        lamp.appr = APPR_EW;
      end
      PH_EW_YELLOW: begin
        lamp.ew   = COL_YELLOW;
        lamp.appr = APPR_EW;
      end
      PH_NST_GREEN: begin
        lamp.nst  = COL_GREEN;
        lamp.appr = APPR_NST;
      end
      default: begin
        // The NS turn yellow, the start code and any code outside the cycle.
        lamp.nst  = COL_YELLOW;
        lamp.appr = APPR_NST;
      end
    endcase
  end

endmodule

@@ hdl/traffic_signal_sequencer.sv @@
// Traffic signal sequencer, top level: phase sequencer, timers and result register.
// Depends on tss_pkg and tss_lamp_decode.
// Result: an accepted tick item's result item is registered onto out_tdata in the next cycle.
// Throughput: one item per clock while out_tready keeps up; the phase step is a single pass of logic.
// Reset (synchronous, rst_n low): start of cycle, timer zero, night mode,
// registers back to their defaults, no result pending.
module traffic_signal_sequencer #(
  parameter int TIME_BITS = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration write port.
  input  logic                          cfg_wr_en,
  input  logic [tss_pkg::CfgAW-1:0]     cfg_addr,
  input  logic [tss_pkg::ThreshW-1:0]   cfg_wdata,
  // Tick items in.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // From bit 0: ns_walk_request, ew_walk_request, ns_turn_request,
  // ew_turn_request, light_level[9:0], two zero pad bits.
  input  logic [tss_pkg::InDataW-1:0]   in_tdata,
  // Result items out.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // From bit 0: ns_lamp[1:0], ns_turn_lamp[1:0], ew_lamp[1:0],
  // ew_turn_lamp[1:0], active_approach[1:0], phase_seconds_left[4:0],
  // walk_active, walk_is_east_west, walk_seconds_left[4:0], buzzer_on, day_flag.
  output logic [tss_pkg::OutDataW-1:0]  out_tdata
);
  import tss_pkg::*;

  // Wide enough for both the timer and the five-bit register/result fields.
  localparam int ExtW = (TIME_BITS > SecsW) ? TIME_BITS : SecsW;

  // Configuration registers.
  logic [SecsW-1:0]   ns_thru_r, ew_thru_r, turn_green_r, yellow_r;
  logic [SecsW-1:0]   ns_walk_r, ew_walk_r;
  logic [ThreshW-1:0] dark_thr_r;

  // Sequencer state.
  tss_phase_t           phase_r, phase_nxt;
  logic [TIME_BITS-1:0] secs_r, secs_nxt;
  logic                 day_r, day_nxt;

  // Result register.
  logic                 out_valid_r;
  logic [OutDataW-1:0]  out_data_r, out_data_nxt;

  logic                 in_fire;
  logic                 ns_walk_req, ew_walk_req, ns_turn_req, ew_turn_req;
  logic [LightW-1:0]    light;
  logic                 reload;
  logic                 cycle_day;
  tss_phase_t           cycle_phase, ew_phase;
  logic [SecsW-1:0]     len_reg;
  logic [ExtW-1:0]      len_ext, secs_ext, wsec_ext;
  logic [TIME_BITS-1:0] len_time, secs_cur;
  tss_lamp_t            lamp;

  // The result register frees itself in the same cycle it is drained, so a
  // new tick is taken every clock while the downstream side keeps up.
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  assign ns_walk_req = in_tdata[0];
  assign ew_walk_req = in_tdata[1];
  assign ns_turn_req = in_tdata[2];
  assign ew_turn_req = in_tdata[3];
  assign light       = in_tdata[LightW+3:4];

  // A phase ends when its timer has run out; a code outside the cycle restarts it.
  assign reload = (secs_r == '0) || (phase_r > PH_NST_YELLOW);

  // Mode for a new cycle: day when the light sample is below the threshold.
  assign cycle_day   = ({1'b0, light} < dark_thr_r);
  assign cycle_phase = (cycle_day && ns_walk_req) ? PH_NS_WALK : PH_NS_GREEN;
  // Walk requests only count in day mode, using the mode of the running cycle.
  assign ew_phase    = (day_r && ew_walk_req) ? PH_EW_WALK : PH_EW_GREEN;

  always_comb begin
    phase_nxt = phase_r;
    day_nxt   = day_r;
    if (reload) begin
      case (phase_r)
        PH_NS_WALK:    phase_nxt = PH_NS_GREEN;
        PH_NS_GREEN:   phase_nxt = PH_NS_YELLOW;
        PH_NS_YELLOW:  phase_nxt = ew_turn_req ? PH_EWT_GREEN : ew_phase;
        PH_EWT_GREEN:  phase_nxt = PH_EWT_YELLOW;
        PH_EWT_YELLOW: phase_nxt = ew_phase;
        PH_EW_WALK:    phase_nxt = PH_EW_GREEN;
        PH_EW_GREEN:   phase_nxt = PH_EW_YELLOW;
        PH_EW_YELLOW: begin
          if (ns_turn_req) begin
            phase_nxt = PH_NST_GREEN;
          end else begin
            phase_nxt = cycle_phase;
            day_nxt   = cycle_day;
          end
        end
        PH_NST_GREEN:  phase_nxt = PH_NST_YELLOW;
        default: begin
          phase_nxt = cycle_phase;
          day_nxt   = cycle_day;
        end
      endcase
    end
  end

  // Length of the phase being entered.
  always_comb begin
    case (phase_nxt)
      PH_NS_WALK:   len_reg = ns_walk_r;
      PH_NS_GREEN:  len_reg = ns_thru_r;
      PH_EWT_GREEN: len_reg = turn_green_r;
      PH_NST_GREEN: len_reg = turn_green_r;
      PH_EW_WALK:   len_reg = ew_walk_r;
      PH_EW_GREEN:  len_reg = ew_thru_r;
      default:      len_reg = yellow_r;
    endcase
  end

  // A length that is zero at the timer width runs for one second.
  assign len_ext  = ExtW'(len_reg);
  assign len_time = (len_ext[TIME_BITS-1:0] == '0) ? TIME_BITS'(1) : len_ext[TIME_BITS-1:0];
  assign secs_cur = reload ? len_time : secs_r;
  assign secs_nxt = secs_cur - TIME_BITS'(1);

  tss_lamp_decode u_lamp (
    .phase (phase_nxt),
    .lamp  (lamp)
  );

  assign secs_ext = ExtW'(secs_cur);
  assign wsec_ext = ExtW'(secs_nxt);

  always_comb begin
    out_data_nxt = {day_nxt,
                    lamp.walk,
                    lamp.walk ? wsec_ext[SecsW-1:0] : {SecsW{1'b0}},
                    lamp.walk_ew,
                    lamp.walk,
                    lamp.walk ? {SecsW{1'b0}} : secs_ext[SecsW-1:0],
                    lamp.appr,
                    lamp.ewt,
                    lamp.ew,
                    lamp.nst,
                    lamp.ns};
  end

  // Configuration writes; an index past the last register is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_thru_r    <= SecsW'(9);
      ew_thru_r    <= SecsW'(8);
      turn_green_r <= SecsW'(7);
      yellow_r     <= SecsW'(3);
      ns_walk_r    <= SecsW'(7);
      ew_walk_r    <= SecsW'(9);
      dark_thr_r   <= ThreshW'(717);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_NS_GREEN:   ns_thru_r    <= cfg_wdata[SecsW-1:0];
        REG_EW_GREEN:   ew_thru_r    <= cfg_wdata[SecsW-1:0];
        REG_TURN_GREEN: turn_green_r <= cfg_wdata[SecsW-1:0];
        REG_YELLOW:     yellow_r     <= cfg_wdata[SecsW-1:0];
        REG_NS_WALK:    ns_walk_r    <= cfg_wdata[SecsW-1:0];
        REG_EW_WALK:    ew_walk_r    <= cfg_wdata[SecsW-1:0];
        REG_DARK_THR:   dark_thr_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer state advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      secs_r  <= '0;
      day_r   <= 1'b0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      secs_r  <= secs_nxt;
      day_r   <= day_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ hdl/tss_checker.sv @@
// Port checker for the traffic signal sequencer, bound to the top level.
// Depends on tss_pkg and traffic_signal_sequencer.
module tss_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [tss_pkg::OutDataW-1:0] out_tdata
);
  import tss_pkg::*;

  logic             walk, walk_ew, buzz, day;
  logic [1:0]       appr;
  logic [SecsW-1:0] psec, wsec;

  assign appr    = out_tdata[9:8];
  assign psec    = out_tdata[14:10];
  assign walk    = out_tdata[15];
  assign walk_ew = out_tdata[16];
  assign wsec    = out_tdata[21:17];
  assign buzz    = out_tdata[22];
  assign day     = out_tdata[23];

  // A stalled result item holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  // Walks only run in day mode, on a through approach, with the buzzer on and the vehicle countdown at zero.
  a_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && walk |-> day && buzz && psec == '0 &&
    (appr == APPR_NS || appr == APPR_EW))
    else $error("inconsistent walk item");

  // Outside a walk the pedestrian fields are quiet.
  a_nowalk: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !walk |-> !walk_ew && !buzz && wsec == '0)
    else $error("pedestrian fields set outside a walk");

  // An east-west walk is shown on the east-west approach.
  a_walk_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && walk_ew |-> walk && appr == APPR_EW)
    else $error("east-west walk on wrong approach");

endmodule

bind traffic_signal_sequencer tss_checker u_tss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ test/tb_traffic_signal_sequencer.sv @@
// Self-checking testbench for the traffic signal sequencer: random and directed tick items,
// a cycle-accurate phase predictor and a result checker, with random gaps on both streams.
// Depends on tss_pkg and the traffic_signal_sequencer RTL.
`timescale 1ns / 1ps

module tb_traffic_signal_sequencer;
  import tss_pkg::*;

  // Register index that decodes to nothing; writes to it must leave the timing alone.
  localparam logic [CfgAW-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned MaxWait = 18;
  localparam int unsigned RandomPhases = 6;
  localparam int unsigned ItemsPerPhase = 71;

  // One tick item as it sits in in_tdata, highest field first.
  typedef struct packed {
    logic [LightW-1:0] light;
    logic              ew_turn;
    logic              ns_turn;
    logic              ew_walk;
    logic              ns_walk;
  } tick_t;

  // One result item as it sits in out_tdata, highest field first.
  typedef struct packed {
    logic             day;
    logic             buzzer;
    logic [SecsW-1:0] walk_secs;
    logic             walk_ew;
    logic             walk;
    logic [SecsW-1:0] phase_secs;
    tss_appr_t        appr;
    tss_color_t       ewt;
    tss_color_t       ew;
    tss_color_t       nst;
    tss_color_t       ns;
  } lamps_t;

  // Tracks the phase sequencer state and the lamp pattern that every accepted tick must
  // produce, and checks the result items against it in order.
  class lamp_checker;
    logic [SecsW-1:0]   ns_thru, ew_thru, turn_green, yellow, ns_walk, ew_walk;
    logic [ThreshW-1:0] dark_thr;
    tss_phase_t         phase;
    logic [SecsW-1:0]   secs_left;
    logic               day;
    lamps_t             lamps_due[$];
    int unsigned        failures;

    function new();
      ns_thru    = 5'd9;
      ew_thru    = 5'd8;
      turn_green = 5'd7;
      yellow     = 5'd3;
      ns_walk    = 5'd7;
      ew_walk    = 5'd9;
      dark_thr   = 11'd717;
      phase      = PH_START;
      secs_left  = '0;
      day        = 1'b0;
      failures   = 0;
    endfunction

    function void set_reg(logic [CfgAW-1:0] idx, logic [ThreshW-1:0] val);
      case (idx)
        REG_NS_GREEN:   ns_thru = val[SecsW-1:0];
        REG_EW_GREEN:   ew_thru = val[SecsW-1:0];
        REG_TURN_GREEN: turn_green = val[SecsW-1:0];
        REG_YELLOW:     yellow = val[SecsW-1:0];
        REG_NS_WALK:    ns_walk = val[SecsW-1:0];
        REG_EW_WALK:    ew_walk = val[SecsW-1:0];
        REG_DARK_THR:   dark_thr = val;
        default: ;
      endcase
    endfunction

    // The mode of a whole cycle is latched from the light sample of its first tick.
    function tss_phase_t cycle_start(tick_t t);
      day = ({1'b0, t.light} < dark_thr);
      return (day && t.ns_walk) ? PH_NS_WALK : PH_NS_GREEN;
    endfunction

    function tss_phase_t ew_entry(tick_t t);
      return (day && t.ew_walk) ? PH_EW_WALK : PH_EW_GREEN;
    endfunction

    function tss_phase_t following(tss_phase_t p, tick_t t);
      case (p)
        PH_NS_WALK:    return PH_NS_GREEN;
        PH_NS_GREEN:   return PH_NS_YELLOW;
        PH_NS_YELLOW:  return t.ew_turn ? PH_EWT_GREEN : ew_entry(t);
        PH_EWT_GREEN:  return PH_EWT_YELLOW;
        PH_EWT_YELLOW: return ew_entry(t);
        PH_EW_WALK:    return PH_EW_GREEN;
        PH_EW_GREEN:   return PH_EW_YELLOW;
        PH_EW_YELLOW:  return t.ns_turn ? PH_NST_GREEN : cycle_start(t);
        PH_NST_GREEN:  return PH_NST_YELLOW;
        default:       return cycle_start(t);
      endcase
    endfunction

    // A programmed length of zero still lasts one second.
    function logic [SecsW-1:0] length_of(tss_phase_t p);
      logic [SecsW-1:0] v;
      case (p)
        PH_NS_WALK:                 v = ns_walk;
        PH_NS_GREEN:                v = ns_thru;
        PH_EWT_GREEN, PH_NST_GREEN: v = turn_green;
        PH_EW_WALK:                 v = ew_walk;
        PH_EW_GREEN:                v = ew_thru;
        default:                    v = yellow;
      endcase
      return (v == '0) ? 5'd1 : v;
    endfunction

    function void note_tick(tick_t t);
      lamps_t r;
      if (secs_left == '0 || phase > PH_NST_YELLOW) begin
        phase = following(phase, t);
        secs_left = length_of(phase);
      end
      r = '0;
      r.ns = COL_RED;
      r.nst = COL_RED;
      r.ew = COL_RED;
      r.ewt = COL_RED;
      r.day = day;
      case (phase)
        PH_NS_WALK: begin
          r.ns = COL_GREEN;
          r.appr = APPR_NS;
          r.walk = 1'b1;
        end
        PH_NS_GREEN: begin
          r.ns = COL_GREEN;
          r.appr = APPR_NS;
        end
        PH_NS_YELLOW: begin
          r.ns = COL_YELLOW;
          r.appr = APPR_NS;
        end
        PH_EWT_GREEN: begin
          r.ewt = COL_GREEN;
          r.appr = APPR_EWT;
        end
        PH_EWT_YELLOW: begin
          r.ewt = COL_YELLOW;
          r.appr = APPR_EWT;
        end
        PH_EW_WALK: begin
          r.ew = COL_GREEN;
          r.appr = APPR_EW;
          r.walk = 1'b1;
          r.walk_ew = 1'b1;
        end
        PH_EW_GREEN: begin
          r.ew = COL_GREEN;
          r.appr = APPR_EW;
        end
        PH_EW_YELLOW: begin
          r.ew = COL_YELLOW;
          r.appr = APPR_EW;
        end
        PH_NST_GREEN: begin
          r.nst = COL_GREEN;
          r.appr = APPR_NST;
        end
        default: begin
          r.nst = COL_YELLOW;
          r.appr = APPR_NST;
        end
      endcase
      // During a walk the pedestrian countdown runs one below the timer and the
      // vehicle countdown reads zero; otherwise the vehicle countdown reads the timer and the pedestrian one zero.
      if (r.walk) begin
        r.walk_secs = secs_left - 5'd1;
        r.buzzer = 1'b1;
      end else begin
        r.phase_secs = secs_left;
      end
      lamps_due.push_back(r);
      secs_left = secs_left - 5'd1;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        failures++;
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_lamps(lamps_t got);
      lamps_t want;
      if (lamps_due.size() == 0) begin
        failures++;
        $display("%0t: result item %h arrived with no tick outstanding", $time, got);
        return;
      end
      want = lamps_due.pop_front();
      compare_field("ns_lamp", want.ns, got.ns);
      compare_field("ns_turn_lamp", want.nst, got.nst);
      compare_field("ew_lamp", want.ew, got.ew);
      compare_field("ew_turn_lamp", want.ewt, got.ewt);
      compare_field("active_approach", want.appr, got.appr);
      compare_field("phase_seconds_left", want.phase_secs, got.phase_secs);
      compare_field("walk_active", want.walk, got.walk);
      compare_field("walk_is_east_west", want.walk_ew, got.walk_ew);
      compare_field("walk_seconds_left", want.walk_secs, got.walk_secs);
      compare_field("buzzer_on", want.buzzer, got.buzzer);
      compare_field("day_flag", want.day, got.day);
    endfunction

    function int unsigned pending();
      return lamps_due.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [CfgAW-1:0]    cfg_addr = '0;
  logic [ThreshW-1:0]  cfg_wdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  lamp_checker lamps = new();
  int unsigned cycle_count = 0;
  // While a burst flag is set that side runs without gaps; the flags flip now and then
  // so that long back-to-back stretches alternate with heavily throttled ones.
  logic        in_burst = 1'b0;
  logic        out_burst = 1'b0;

  traffic_signal_sequencer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("traffic_signal_sequencer verification failed");
      $finish;
    end
  end

  function automatic tick_t mk_tick(logic nsw, logic eww, logic nst, logic ewt,
                                    logic [LightW-1:0] light);
    tick_t t;
    t.ns_walk = nsw;
    t.ew_walk = eww;
    t.ns_turn = nst;
    t.ew_turn = ewt;
    t.light = light;
    return t;
  endfunction

  // Requests are fair coin flips; the light sample leans on its two extremes.
  function automatic tick_t random_tick();
    tick_t       t;
    logic [31:0] r;
    r = $urandom;
    t = r[13:0];
    case ($urandom_range(0, 7))
      0: t.light = '0;
      1: t.light = '1;
      default: ;
    endcase
    return t;
  endfunction

  // Mostly short phases so that many cycles go by, with the occasional longest one.
  function automatic logic [SecsW-1:0] pick_len();
    logic [31:0] r;
    if ($urandom_range(0, 7) == 0)
      return '1;
    r = $urandom_range(0, 4);
    return r[SecsW-1:0];
  endfunction

  function automatic logic [ThreshW-1:0] pick_thr();
    logic [31:0] r;
    if ($urandom_range(0, 3) == 0)
      return 11'd717;
    r = $urandom_range(1, 1023);
    return r[ThreshW-1:0];
  endfunction

  // Drives one write and leaves the enable high; the caller drops it after the last write
  // so that back-to-back writes never see a low and a high in the same step.
  task automatic write_reg(input logic [CfgAW-1:0] idx, input logic [ThreshW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    lamps.set_reg(idx, val);
  endtask

  // Writes every register. The six length registers carry random junk in the bits above
  // their width, which the block has to drop. A write to the unused index goes along too.
  task automatic program_timing(input logic [SecsW-1:0] nsg, input logic [SecsW-1:0] ewg,
                                input logic [SecsW-1:0] turn, input logic [SecsW-1:0] yel,
                                input logic [SecsW-1:0] nsw, input logic [SecsW-1:0] eww,
                                input logic [ThreshW-1:0] thr);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(REG_NS_GREEN, {junk[5:0], nsg});
    write_reg(REG_EW_GREEN, {junk[11:6], ewg});
    write_reg(REG_TURN_GREEN, {junk[17:12], turn});
    write_reg(REG_YELLOW, {junk[23:18], yel});
    write_reg(REG_NS_WALK, {junk[29:24], nsw});
    write_reg(REG_EW_WALK, {junk[31:30], junk[3:0], eww});
    write_reg(REG_DARK_THR, thr);
    write_reg(REG_UNUSED, junk[ThreshW-1:0]);
    cfg_wr_en <= 1'b0;
  endtask

  // Offers one tick after a random gap and returns at the edge where it is taken.
  task automatic send_tick(input tick_t t);
    int unsigned gap;
    if ($urandom_range(0, 31) == 0)
      in_burst = ~in_burst;
    gap = in_burst ? 0 : $urandom_range(0, MaxWait);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, t};
    do @(posedge clk); while (in_tready !== 1'b1);
    lamps.note_tick(t);
  endtask

  // Stops offering ticks and waits until every result has been checked, so that the
  // registers can be rewritten with nothing in flight.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (lamps.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Result side: a random stall before each result item, then take it and check it.
  initial begin : result_sink
    int unsigned stall;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(0, 31) == 0)
        out_burst = ~out_burst;
      stall = out_burst ? 0 : $urandom_range(0, MaxWait);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      lamps.check_lamps(out_tdata);
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Straight out of reset: the default timings and threshold apply. A dark-free sample
    // with a walk request opens a day cycle with the seven-second north-south walk.
    send_tick(mk_tick(1'b1, 1'b1, 1'b1, 1'b1, 10'd0));
    drain();

    // Zero in every length register means one second each, which lets a whole cycle
    // pass in a handful of ticks.
    program_timing('0, '0, '0, '0, '0, '0, 11'd717);
    // Finish the walk begun under the default length; requests here are not looked at.
    repeat (6) send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 10'd1023));
    // Just under the threshold: day, every request raised, so all ten phases run.
    repeat (10) send_tick(mk_tick(1'b1, 1'b1, 1'b1, 1'b1, 10'd716));
    // Exactly at the threshold would be night, but the running cycle keeps its day mode.
    repeat (6) send_tick(mk_tick(1'b1, 1'b1, 1'b1, 1'b1, 10'd717));
    // One more tick with no requests moves on to east-west yellow.
    send_tick(mk_tick(1'b0, 1'b0, 1'b0, 1'b0, 10'd0));
    drain();

    for (int ph = 0; ph < RandomPhases; ph++) begin
      case (ph)
        // Longest phases everywhere and a threshold past the sensor range: always day.
        0: program_timing('1, '1, '1, '1, '1, '1, '1);
        // Shortest phases and a zero threshold: night for every cycle.
        1: program_timing('0, '0, '0, '0, '0, '0, '0);
        // Threshold just past the top sample value still means day.
        2: program_timing(pick_len(), pick_len(), pick_len(), pick_len(), pick_len(),
                          pick_len(), 11'd1024);
        default: program_timing(pick_len(), pick_len(), pick_len(), pick_len(), pick_len(),
                                pick_len(), pick_thr());
      endcase
      repeat (ItemsPerPhase) send_tick(random_tick());
      drain();
    end

    repeat (8) @(posedge clk);
    if (lamps.failures == 0 && lamps.pending() == 0)
      $display("traffic_signal_sequencer verification clean");
    else
      $display("traffic_signal_sequencer verification failed");
    $finish;
  end

endmodule

@@ traffic_signal_sequencer.f @@
hdl/tss_pkg.sv
hdl/tss_lamp_decode.sv
hdl/traffic_signal_sequencer.sv
hdl/tss_checker.sv
test/tb_traffic_signal_sequencer.sv
